>>> rtl/core/slcfr_pkg.sv
// Shared types and constants for the sync/length/checksum frame receiver.
`timescale 1ns / 1ps

package slcfr_pkg;

  // Framing constants
  localparam logic [7:0] SYNC_BYTE     = 8'h7E;
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // Input kind carried in tuser
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic tick;         // count the inactivity timer down
    logic reload;       // reload the inactivity timer
    logic start_frame;  // sync seen: clear sum, index and length flag
    logic take_len;     // capture the length byte
    logic take_body;    // store and sum a frame byte
    logic err_csum;     // load a checksum mismatch result
    logic err_long;     // load a frame too long result
    logic start_emit;   // rewind the read pointer
    logic rd_issue;     // read the frame store
    logic emit_load;    // load a frame byte result
  } slcfr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_sync;      // incoming byte is the sync byte
    logic len_done;     // no frame bytes left after this one
    logic too_long;     // announced frame exceeds the store
    logic sum_match;    // running sum equals incoming byte
    logic timer_expire; // timer is zero after this tick
    logic rd_last;      // current read is the final stored byte
    logic out_free;     // output register can take a result
  } slcfr_sts_t;

endpackage

>>> rtl/core/sync_length_checksum_frame_receiver_unit.sv
// Top level of the sync/length/checksum frame receiver.
// Input: one transfer per cycle while parsing, held off while a result waits in the
// output register; an error result is offered in the cycle after the checksum transfer.
// Good frame of K bytes: each byte is read from the store, then loaded into the output
// register once it is free; input held off until the last byte is taken.
// Reset (rst_ni low, asynchronous): hunting for sync, timer 0, timeout 5.
`timescale 1ns / 1ps

module sync_length_checksum_frame_receiver_unit
  import slcfr_pkg::*;
#(
  parameter int BUF_DEPTH = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: timeout_ticks
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_data
  input  logic        s_axis_tuser_i,   // [0] cmd
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_byte, [12:8] byte_index
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o    // last
);

  slcfr_cmd_t cmd;
  slcfr_sts_t sts;
  logic [7:0] out_byte;
  logic [4:0] out_index;

  slcfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slcfr_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (s_axis_tdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (m_axis_tuser_o),
    .out_byte_o   (out_byte),
    .out_index_o  (out_index),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack result fields, zero fill to whole bytes
  assign m_axis_tdata_o = {3'b000, out_index, out_byte};

endmodule

>>> rtl/core/slcfr_ctrl.sv
// Controller state machine: frame parsing and result emission sequencing.
`timescale 1ns / 1ps

module slcfr_ctrl
  import slcfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  input  slcfr_sts_t sts_i,
  output slcfr_cmd_t cmd_o
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_LEN     = 3'd1;
  localparam logic [2:0] ST_BODY    = 3'd2;
  localparam logic [2:0] ST_CSUM    = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;

  logic [2:0] state_q, state_d;
  logic       parsing;
  logic       accept;

  // Inputs are taken only while parsing and with room for a result
  assign parsing    = (state_q == ST_HUNT) || (state_q == ST_LEN) ||
                      (state_q == ST_BODY) || (state_q == ST_CSUM);
  assign in_ready_o = parsing && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (accept && (in_kind_i == KIND_TICK)) begin
      cmd_o.tick = 1'b1;
      if (sts_i.timer_expire && (state_q != ST_HUNT)) begin
        state_d = ST_HUNT;
      end
    end else if (accept) begin
      cmd_o.reload = 1'b1;
      case (state_q)
        ST_HUNT: begin
          if (sts_i.is_sync) begin
            cmd_o.start_frame = 1'b1;
            state_d           = ST_LEN;
          end
        end
        ST_LEN: begin
          cmd_o.take_len = 1'b1;
          state_d        = ST_BODY;
        end
        ST_BODY: begin
          cmd_o.take_body = 1'b1;
          if (sts_i.len_done) begin
            state_d = ST_CSUM;
          end
        end
        ST_CSUM: begin
          if (sts_i.too_long) begin
            cmd_o.err_long = 1'b1;
            state_d        = ST_HUNT;
          end else if (!sts_i.sum_match) begin
            cmd_o.err_csum = 1'b1;
            state_d        = ST_HUNT;
          end else begin
            cmd_o.start_emit = 1'b1;
            state_d          = ST_EMIT_RD;
          end
        end
        default: begin
          state_d = ST_HUNT;
        end
      endcase
    end else begin
      case (state_q)
        ST_EMIT_RD: begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (sts_i.out_free) begin
            cmd_o.emit_load = 1'b1;
            state_d         = sts_i.rd_last ? ST_HUNT : ST_EMIT_RD;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/slcfr_dp.sv
// Datapath: timer, running sum, counters, frame store and output register.
`timescale 1ns / 1ps

module slcfr_dp
  import slcfr_pkg::*;
#(
  parameter int BUF_DEPTH = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic [7:0] rx_byte_i,
  input  slcfr_cmd_t cmd_i,
  output slcfr_sts_t sts_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [1:0] out_status_o,
  output logic [7:0] out_byte_o,
  output logic [4:0] out_index_o,
  output logic       out_last_o
);

  localparam int          ADDR_W = $clog2(BUF_DEPTH);
  localparam int          CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam logic [8:0]  DEPTH9 = 9'(BUF_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

  logic [7:0]       timeout_q;
  logic [7:0]       timer_q;
  logic [7:0]       sum_q;
  logic [7:0]       left_q;
  logic             too_long_q;
  logic [CNT_W-1:0] wr_idx_q;
  logic [CNT_W-1:0] rd_idx_q;
  logic [CNT_W-1:0] rd_next;
  logic [7:0]       rd_data_q;
  logic [7:0]       store_q [BUF_DEPTH];
  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic [7:0]       out_byte_q;
  logic [4:0]       out_index_q;
  logic             out_last_q;
  logic             store_wr;

  assign rd_next  = rd_idx_q + CNT_W'(1);
  assign store_wr = cmd_i.take_body && !too_long_q && (wr_idx_q < DEPTH_CNT);

  // Status back to the controller
  always_comb begin
    sts_o.is_sync      = (rx_byte_i == SYNC_BYTE);
    sts_o.len_done     = (left_q == 8'd0);
    sts_o.too_long     = too_long_q;
    sts_o.sum_match    = (sum_q == rx_byte_i);
    sts_o.timer_expire = (timer_q == 8'd0) || (timer_q == 8'd1);
    sts_o.rd_last      = (rd_next == wr_idx_q);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Timeout register and inactivity timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      timer_q   <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.reload) begin
        timer_q <= timeout_q;
      end else if (cmd_i.tick && (timer_q != 8'd0)) begin
        timer_q <= timer_q - 8'd1;
      end
    end
  end

  // Frame bookkeeping: sum, remaining length, write and read pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= 8'd0;
      left_q     <= 8'd0;
      too_long_q <= 1'b0;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
    end else begin
      if (cmd_i.start_frame) begin
        sum_q      <= 8'd0;
        wr_idx_q   <= '0;
        too_long_q <= 1'b0;
      end
      if (cmd_i.take_len) begin
        left_q     <= rx_byte_i;
        sum_q      <= sum_q + rx_byte_i;
        too_long_q <= ({1'b0, rx_byte_i} + 9'd1) > DEPTH9;
        wr_idx_q   <= '0;
      end
      if (cmd_i.take_body) begin
        sum_q <= sum_q + rx_byte_i;
        if (left_q != 8'd0) begin
          left_q <= left_q - 8'd1;
        end
        if (store_wr) begin
          wr_idx_q <= wr_idx_q + CNT_W'(1);
        end
      end
      if (cmd_i.start_emit) begin
        rd_idx_q <= '0;
      end else if (cmd_i.emit_load) begin
        rd_idx_q <= rd_next;
      end
    end
  end

  // Frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[wr_idx_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= store_q[rd_idx_q[ADDR_W-1:0]];
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.err_csum || cmd_i.err_long || cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.err_csum || cmd_i.err_long) begin
      out_status_q <= cmd_i.err_long ? STATUS_TOO_LONG : STATUS_CSUM_ERR;
      out_byte_q   <= 8'd0;
      out_index_q  <= 5'd0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_load) begin
      out_status_q <= STATUS_OK;
      out_byte_q   <= rd_data_q;
      out_index_q  <= 5'(rd_idx_q);
      out_last_q   <= (rd_next == wr_idx_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_byte_o   = out_byte_q;
  assign out_index_o  = out_index_q;
  assign out_last_o   = out_last_q;

endmodule
